// ===== rtl/vms_pkg.sv =====
// Shared constants and helpers for the von Mises trial pipeline.
`timescale 1ns / 1ps
`default_nettype none
package vms_pkg;

    // Default fractional bits of the angle format
    localparam int ANGLE_FRAC_BITS_DEF = 27;

    // Register indexes (word address bits [3:2])
    localparam logic [1:0] REG_LOCATION      = 2'd0;
    localparam logic [1:0] REG_CONCENTRATION = 2'd1;
    localparam logic [1:0] REG_SCALE         = 2'd2;

    localparam logic [31:0] LOCATION_RST      = 32'd0;
    localparam logic [31:0] CONCENTRATION_RST = 32'd65536;
    localparam logic [31:0] SCALE_RST         = 32'd1240952418;

    localparam logic [31:0] ONE_Q16     = 32'd65536;
    localparam logic [30:0] PI_Q29      = 31'd1686629713;
    localparam logic [31:0] TWO_LN2_Q31 = 32'd2977044472;

    // Versine series coefficients, Q.32
    localparam logic [31:0] VERS_C0 = 32'd2147483648;
    localparam logic [31:0] VERS_C1 = 32'd178956971;
    localparam logic [31:0] VERS_C2 = 32'd5965232;
    localparam logic [31:0] VERS_C3 = 32'd106522;
    localparam logic [31:0] VERS_C4 = 32'd1184;

    // Stage counts of the divider and the log unit
    localparam int DIV_LAT = 32;
    localparam int LOG_LAT = 35;

    // Upper half of a 32x32 product
    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = 64'(a) * 64'(b);
        return p[63:32];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/vms_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module vms_div
    import vms_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [63:0] dividend,
    input  wire logic [31:0] divisor,
    output logic      [31:0] quot,
    output logic      [31:0] dsor_out
);

    logic [31:0] rem_reg [0:DIV_LAT-1];
    logic [31:0] lo_reg  [0:DIV_LAT-1];
    logic [31:0] q_reg   [0:DIV_LAT-1];
    logic [31:0] d_reg   [0:DIV_LAT-1];

    genvar j;
    generate
        for (j = 0; j < DIV_LAT; j++) begin : g_stage
            logic [31:0] rem_in, lo_in, q_in, d_in;
            logic [32:0] r33, diff;
            logic [31:0] rem_next, lo_next, q_next;

            if (j == 0) begin : g_first
                assign rem_in = dividend[63:32];
                assign lo_in  = dividend[31:0];
                assign q_in   = '0;
                assign d_in   = divisor;
            end else begin : g_rest
                assign rem_in = rem_reg[j-1];
                assign lo_in  = lo_reg[j-1];
                assign q_in   = q_reg[j-1];
                assign d_in   = d_reg[j-1];
            end

            always_comb begin
                r33  = {rem_in, lo_in[31]};
                diff = r33 - {1'b0, d_in};
                if (r33 >= {1'b0, d_in}) begin
                    rem_next = diff[31:0];
                    q_next   = {q_in[30:0], 1'b1};
                end else begin
                    rem_next = r33[31:0];
                    q_next   = {q_in[30:0], 1'b0};
                end
                lo_next = {lo_in[30:0], 1'b0};
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[j] <= rem_next;
                    lo_reg[j]  <= lo_next;
                    q_reg[j]   <= q_next;
                    d_reg[j]   <= d_in;
                end
            end
        end
    endgenerate

    assign quot     = q_reg[DIV_LAT-1];
    assign dsor_out = d_reg[DIV_LAT-1];

endmodule
`default_nettype wire

// ===== rtl/vms_log.sv =====
// Pipelined -2 ln(u) in Q.47 by normalization and repeated squaring.
`timescale 1ns / 1ps
`default_nettype none
module vms_log
    import vms_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [31:0] u,
    output logic      [63:0] neg2ln
);

    localparam int NSQ = 32;

    logic [31:0] m0_reg;
    logic [5:0]  ec0_reg;
    logic [31:0] m_reg  [0:NSQ-1];
    logic [31:0] f_reg  [0:NSQ-1];
    logic [5:0]  ec_reg [0:NSQ-1];
    logic [37:0] n_reg;
    logic [63:0] out_reg;

    logic [4:0]  e_msb;
    logic [31:0] m0_next;

    // Find the leading one; scale it to bit 31
    always_comb begin
        e_msb = '0;
        for (int i = 0; i < 32; i++) begin
            if (u[i]) e_msb = 5'(i);
        end
        m0_next = u << (5'd31 - e_msb);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m0_reg  <= m0_next;
            ec0_reg <= 6'd32 - {1'b0, e_msb};
        end
    end

    genvar j;
    generate
        for (j = 0; j < NSQ; j++) begin : g_sq
            logic [31:0] m_in, f_in;
            logic [5:0]  ec_in;
            logic [63:0] sq;
            logic [32:0] m2;
            logic [31:0] m_next;
            logic        bit_next;

            if (j == 0) begin : g_first
                assign m_in  = m0_reg;
                assign f_in  = '0;
                assign ec_in = ec0_reg;
            end else begin : g_rest
                assign m_in  = m_reg[j-1];
                assign f_in  = f_reg[j-1];
                assign ec_in = ec_reg[j-1];
            end

            always_comb begin
                sq = 64'(m_in) * 64'(m_in);
                m2 = sq[63:31];
                if (m2[32]) begin
                    m_next   = m2[32:1];
                    bit_next = 1'b1;
                end else begin
                    m_next   = m2[31:0];
                    bit_next = 1'b0;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    m_reg[j]  <= m_next;
                    f_reg[j]  <= {f_in[30:0], bit_next};
                    ec_reg[j] <= ec_in;
                end
            end
        end
    endgenerate

    logic [63:0] p_hi, p_lo;

    always_comb begin
        p_hi = 64'(n_reg[37:16]) * 64'(TWO_LN2_Q31);
        p_lo = (64'(n_reg[15:0]) * 64'(TWO_LN2_Q31)) >> 16;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg   <= {ec_reg[NSQ-1], 32'd0} - {6'd0, f_reg[NSQ-1]};
            out_reg <= p_hi + p_lo;
        end
    end

    assign neg2ln = out_reg;

endmodule
`default_nettype wire

// ===== rtl/von_mises_sample_trial_top.sv =====
// Top level of the von Mises ratio-of-uniforms trial pipeline.
`timescale 1ns / 1ps
`default_nettype none
// One trial per input word: u and v come in on the s_ stream, the accept flag and mu + theta
// leave on the m_ stream. The pipeline takes one word every cycle unless the output stalls
// it and keeps results in order; each word runs through all stages to the output register
// (44 register stages: input, product, a 32-stage bit-per-stage divider, square, four series
// steps, the versine refinement, the k product and the output). The log of u runs beside the
// divider in a 35-stage squaring unit. The whole pipe advances on one enable: it moves when
// the output register is empty or being read, so s_tready follows m_tready while a result
// waits. Write the APB registers only while no word is in flight; a zero concentration acts
// as 1.0, and envelope_scale must be supplied by software to match the concentration.
module von_mises_sample_trial_top
    import vms_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [31:0] uniform_u, [63:32] uniform_v
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // [31:0] sample_angle
    output logic             m_tuser,   // [0] accepted
    // APB configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    // Stage numbers
    localparam int S_IN   = 0;
    localparam int S_PROD = 1;
    localparam int S_REJ  = 2;
    localparam int S_DIV  = S_PROD + DIV_LAT;
    localparam int S_SQ   = S_DIV + 1;
    localparam int S_T3   = S_SQ + 1;
    localparam int S_T2   = S_SQ + 2;
    localparam int S_T1   = S_SQ + 3;
    localparam int S_T0   = S_SQ + 4;
    localparam int S_H    = S_SQ + 5;
    localparam int S_H1   = S_SQ + 6;
    localparam int S_H2   = S_SQ + 7;
    localparam int S_KV   = S_SQ + 8;
    localparam int S_OUT  = S_SQ + 9;
    localparam int S_LOG  = S_IN + LOG_LAT;
    localparam int SHIFT  = 30 - ANGLE_FRAC_BITS;

    // ---------------- configuration ----------------
    logic [31:0] loc_reg, conc_reg, scale_reg;
    logic        wr_en;
    logic [31:0] k_eff;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign k_eff  = (conc_reg == 32'd0) ? ONE_Q16 : conc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loc_reg   <= LOCATION_RST;
            conc_reg  <= CONCENTRATION_RST;
            scale_reg <= SCALE_RST;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_LOCATION:      loc_reg   <= pwdata;
                REG_CONCENTRATION: conc_reg  <= pwdata;
                REG_SCALE:         scale_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_LOCATION:      prdata = loc_reg;
            REG_CONCENTRATION: prdata = conc_reg;
            REG_SCALE:         prdata = scale_reg;
            default:           prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // Advance every stage together; hold all when the output word is stuck.
    logic en;
    logic vld_reg [S_IN:S_OUT];

    assign en       = !vld_reg[S_OUT] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[S_OUT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = S_IN; i <= S_OUT; i++) vld_reg[i] <= 1'b0;
        end else if (en) begin
            vld_reg[S_IN] <= s_tvalid;
            for (int i = S_IN + 1; i <= S_OUT; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    // ---------------- input and envelope bound ----------------
    logic [31:0] u0_reg, vmag0_reg, u1_reg;
    logic [63:0] prod_reg, pu_reg;
    logic        neg_reg [S_IN:S_DIV];
    logic        rej_reg [S_REJ:S_KV];

    always_ff @(posedge aclk) begin
        if (en) begin
            u0_reg     <= s_tdata[31:0];
            // magnitude of v; the most negative code maps to 2^31 by wraparound
            vmag0_reg  <= s_tdata[63] ? (~s_tdata[63:32] + 32'd1) : s_tdata[63:32];
            neg_reg[S_IN] <= s_tdata[63];
            for (int i = S_IN + 1; i <= S_DIV; i++) neg_reg[i] <= neg_reg[i-1];

            u1_reg   <= u0_reg;
            prod_reg <= 64'(scale_reg) * 64'(vmag0_reg);
            pu_reg   <= 64'(PI_Q29) * 64'(u0_reg);

            // reject zero u and anything outside the envelope
            rej_reg[S_REJ] <= (u1_reg == 32'd0) || (prod_reg > pu_reg);
            for (int i = S_REJ + 1; i <= S_KV; i++) rej_reg[i] <= rej_reg[i-1];
        end
    end

    // ---------------- theta = floor(2*prod/u), Q.30 ----------------
    logic [31:0] t30, u_div;

    vms_div u_div_pipe (
        .aclk     (aclk),
        .en       (en),
        .dividend ({prod_reg[62:0], 1'b0}),
        .divisor  (u1_reg),
        .quot     (t30),
        .dsor_out (u_div)
    );

    // ---------------- -2 ln u, beside the divider ----------------
    logic [63:0] log_out;
    logic [63:0] log_reg [S_LOG+1:S_KV];

    vms_log u_log (
        .aclk   (aclk),
        .en     (en),
        .u      (u0_reg),
        .neg2ln (log_out)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            log_reg[S_LOG+1] <= log_out;
            for (int i = S_LOG + 2; i <= S_KV; i++) log_reg[i] <= log_reg[i-1];
        end
    end

    // ---------------- square, sum and test A ----------------
    logic [31:0] x_reg   [S_SQ:S_T0];
    logic [31:0] usq_reg;
    logic [31:0] sum_reg [S_SQ:S_KV];
    logic        ta_reg  [S_T3:S_KV];

    logic [31:0] th;
    logic [33:0] mu_x, th_x, sum_x;
    logic [31:0] sum_sat;
    logic [63:0] kx, lim;
    logic [32:0] one_minus_u;

    always_comb begin
        th    = t30 >> SHIFT;
        mu_x  = {{2{loc_reg[31]}}, loc_reg};
        th_x  = {2'b00, th};
        sum_x = neg_reg[S_DIV] ? (mu_x - th_x) : (mu_x + th_x);
        // saturate to the signed 32-bit range
        if (!sum_x[33] && (sum_x[32:31] != 2'b00))
            sum_sat = 32'h7FFF_FFFF;
        else if (sum_x[33] && (sum_x[32:31] != 2'b11))
            sum_sat = 32'h8000_0000;
        else
            sum_sat = sum_x[31:0];

        one_minus_u = 33'h1_0000_0000 - {1'b0, usq_reg};
        lim         = 64'(one_minus_u) << 14;
        kx          = 64'(k_eff) * 64'(x_reg[S_SQ]);
    end

    // ---------------- versine series and refinement ----------------
    logic [31:0] t3_reg, t2_reg, t1_reg, t0_reg, h_reg;
    logic [32:0] h1_reg, h2_reg;
    logic [64:0] kv_reg;

    logic [33:0] hx, hg;
    logic [67:0] hp;
    logic [35:0] h1_raw;
    logic [32:0] h1_next, g2;
    logic [65:0] p2;
    logic        acc_next;

    always_comb begin
        hx      = {2'b00, h_reg};
        hg      = 34'h2_0000_0000 - hx;
        hp      = 68'(hx) * 68'(hg);
        h1_raw  = hp[67:32];
        // clamp to 1.0 in Q.31 doubled (2^32)
        h1_next = (h1_raw > 36'h1_0000_0000) ? 33'h1_0000_0000 : h1_raw[32:0];

        g2 = 33'h1_0000_0000 - h1_reg;
        p2 = 66'(h1_reg) * 66'(g2);

        acc_next = !rej_reg[S_KV] && (ta_reg[S_KV] || (kv_reg <= {1'b0, log_reg[S_KV]}));
    end

    logic        acc_reg;
    logic [31:0] out_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[S_SQ]   <= mul32(t30, t30);
            for (int i = S_SQ + 1; i <= S_T0; i++) x_reg[i] <= x_reg[i-1];
            usq_reg       <= u_div;
            sum_reg[S_SQ] <= sum_sat;
            for (int i = S_SQ + 1; i <= S_KV; i++) sum_reg[i] <= sum_reg[i-1];

            ta_reg[S_T3] <= kx < lim;
            for (int i = S_T3 + 1; i <= S_KV; i++) ta_reg[i] <= ta_reg[i-1];

            // Horner steps of the series in x = (theta/4)^2
            t3_reg <= VERS_C3 - mul32(x_reg[S_SQ], VERS_C4);
            t2_reg <= VERS_C2 - mul32(x_reg[S_T3], t3_reg);
            t1_reg <= VERS_C1 - mul32(x_reg[S_T2], t2_reg);
            t0_reg <= VERS_C0 - mul32(x_reg[S_T1], t1_reg);
            h_reg  <= mul32(x_reg[S_T0], t0_reg);

            // double-angle steps back to theta
            h1_reg <= h1_next;
            h2_reg <= p2[62:30];
            kv_reg <= 65'(k_eff) * 65'(h2_reg);

            acc_reg <= acc_next;
            out_reg <= acc_next ? sum_reg[S_KV] : 32'd0;
        end
    end

    assign m_tuser = acc_reg;
    assign m_tdata = out_reg;

endmodule
`default_nettype wire

// ===== tb/sv/von_mises_sample_trial_top_test.sv =====
// Self-checking testbench for the von Mises ratio-of-uniforms trial pipeline.
`timescale 1ns / 1ps
`default_nettype none
module von_mises_sample_trial_top_test;
    import vms_pkg::*;

    localparam int FRAC = ANGLE_FRAC_BITS_DEF;
    localparam int PIPE_LAT = 44;

    typedef struct packed {
        logic        accepted;
        logic [31:0] angle;
    } trial_result_t;

    typedef struct {
        logic [31:0] u;
        logic [31:0] v;
        logic        known;     // expected result typed in below
        logic        acc;
        logic [31:0] angle;
    } trial_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    von_mises_sample_trial_top dut (.*);

    // Clock: 10 ns period.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow copies of the registers.
    logic [31:0] mdl_location = LOCATION_RST;
    logic [31:0] mdl_concentration = CONCENTRATION_RST;
    logic [31:0] mdl_scale = SCALE_RST;

    trial_result_t pending_results[$];
    int  mismatches = 0;
    bit  idle_enable = 1'b0;    // random idling on both sides
    int  hold_off = 0;          // cycles for the receiver to stall outright

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // 1 - cos(theta) in Q.31 from theta in Q.30.
    function automatic logic [63:0] versine_of(input logic [63:0] t30);
        logic [63:0] x, t, h, h1;
        x = (t30 * t30) >> 32;
        t = 64'(VERS_C4);
        t = 64'(VERS_C3) - ((x * t) >> 32);
        t = 64'(VERS_C2) - ((x * t) >> 32);
        t = 64'(VERS_C1) - ((x * t) >> 32);
        t = 64'(VERS_C0) - ((x * t) >> 32);
        h = (x * t) >> 32;
        h1 = (h * ((64'd1 << 33) - h)) >> 32;
        if (h1 > (64'd1 << 32)) h1 = 64'd1 << 32;
        return (h1 * ((64'd1 << 32) - h1)) >> 30;
    endfunction

    // -2 ln u in Q.47, u nonzero.
    function automatic logic [63:0] neg_two_ln_of(input logic [31:0] u);
        int e;
        logic [63:0] m, f, n;
        e = 31;
        f = 0;
        while (e > 0 && !u[e]) e--;
        m = 64'(u) << (31 - e);
        for (int i = 0; i < 32; i++) begin
            m = (m * m) >> 31;
            f = f << 1;
            if (m >= (64'd1 << 32)) begin
                m = m >> 1;
                f[0] = 1'b1;
            end
        end
        n = (64'(32 - e) << 32) - f;
        return (n >> 16) * 64'(TWO_LN2_Q31) + (((n & 64'hFFFF) * 64'(TWO_LN2_Q31)) >> 16);
    endfunction

    function automatic trial_result_t predict_trial(input logic [31:0] u,
                                                    input logic [31:0] v);
        trial_result_t r;
        logic        neg;
        logic [31:0] vneg;
        logic [63:0] vmag, k, prod, q, rem, t30, t2;
        logic        acc;
        longint      th, sum;
        r = '0;
        neg = v[31];
        // two's complement magnitude kept at 32 bits
        vneg = ~v + 32'd1;
        vmag = neg ? 64'(vneg) : 64'(v);
        if (neg && vmag == 0) vmag = 64'd1 << 31;
        k = (mdl_concentration != 0) ? 64'(mdl_concentration) : 64'(ONE_Q16);
        if (u == 0) return r;
        prod = 64'(mdl_scale) * vmag;
        if (prod > 64'(PI_Q29) * 64'(u)) return r;
        q = prod / 64'(u);
        rem = prod % 64'(u);
        t30 = 2 * q + ((2 * rem >= 64'(u)) ? 64'd1 : 64'd0);
        t2 = (t30 * t30) >> 32;
        acc = (k * t2) < (((64'd1 << 32) - 64'(u)) << 14);
        if (!acc) acc = (k * versine_of(t30)) <= neg_two_ln_of(u);
        if (acc) begin
            th = longint'(t30 >> (30 - FRAC));
            sum = longint'(signed'(mdl_location)) + (neg ? -th : th);
            if (sum > 64'sd2147483647) sum = 64'sd2147483647;
            if (sum < -64'sd2147483648) sum = -64'sd2147483648;
            r.accepted = 1'b1;
            r.angle = sum[31:0];
        end
        return r;
    endfunction

    // Hold each word until the handshake; idle between words at random.
    // Valid stays high after the handshake; the next word replaces the data, and an idle drops valid.
    task automatic send_trial(input logic [31:0] u, input logic [31:0] v);
        while (idle_enable && $urandom_range(99) < 18) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {v, u};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(predict_trial(u, v));
        @(negedge aclk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_LOCATION:      mdl_location = value;
            REG_CONCENTRATION: mdl_concentration = value;
            REG_SCALE:         mdl_scale = value;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (PIPE_LAT + 4) @(negedge aclk);
    endtask

    // Receiver: stall at random or for a counted hold-off; check every word.
    always @(negedge aclk) begin
        if (hold_off > 0) begin
            m_tready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            m_tready <= !(idle_enable && $urandom_range(99) < 18);
        end
    end

    always @(posedge aclk) begin
        trial_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word", m_tdata, 32'h0);
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.accepted)
                    report_mismatch("accepted", 32'(m_tuser), 32'(want.accepted));
                if (m_tdata !== want.angle)
                    report_mismatch("sample_angle", m_tdata, want.angle);
            end
        end
    end

    // Directed rows; the typed-in results assume the reset registers.
    trial_row_t directed_rows[] = '{
        '{32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0},           // zero u
        '{32'h0000_0000, 32'h8000_0000, 1'b1, 1'b0, 32'h0},
        '{32'h0000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0, 32'h0},
        '{32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h0},           // zero v
        '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h0},
        '{32'h0000_0001, 32'h0000_0000, 1'b1, 1'b1, 32'h0},
        '{32'h0000_0001, 32'h7FFF_FFFF, 1'b1, 1'b0, 32'h0},           // outside envelope
        '{32'h0000_0001, 32'h8000_0000, 1'b1, 1'b0, 32'h0},
        '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
        '{32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
        '{32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 1'b0, 32'h0},
        '{32'h4000_0000, 32'h2000_0000, 1'b0, 1'b0, 32'h0},
        '{32'h4000_0000, 32'hE000_0000, 1'b0, 1'b0, 32'h0},
        '{32'h0100_0000, 32'h0080_0000, 1'b0, 1'b0, 32'h0},
        '{32'h8000_0000, 32'h4000_0000, 1'b0, 1'b0, 32'h0},
        '{32'h0000_1000, 32'hFFFF_F000, 1'b0, 1'b0, 32'h0}
    };

    // One random trial, biased toward the envelope so accepts are common.
    task automatic random_trial;
        logic [31:0] u, v;
        u = $urandom();
        case ($urandom_range(9))
            0: u = $urandom_range(255);
            1: u = 32'hFFFF_FFFF - $urandom_range(255);
            default: ;
        endcase
        v = $urandom();
        case ($urandom_range(9))
            0, 1, 2: v = 32'(signed'(v) >>> $urandom_range(8, 1));
            3, 4:    v = 32'(signed'(v) >>> $urandom_range(24, 9));
            5:       v = 32'h8000_0000;
            default: ;
        endcase
        send_trial(u, v);
    endtask

    initial begin
        trial_result_t want;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: reset registers, then against typed rows or the predictor.
        foreach (directed_rows[i]) begin
            if (directed_rows[i].known) begin
                want.accepted = directed_rows[i].acc;
                want.angle = directed_rows[i].angle;
                if (predict_trial(directed_rows[i].u, directed_rows[i].v) !== want)
                    report_mismatch("table row", 32'(i), 32'h0);
            end
            send_trial(directed_rows[i].u, directed_rows[i].v);
        end
        drain();

        // Saturation at both ends of the angle range.
        apb_write(REG_LOCATION, 32'h7FFF_FFF0);
        send_trial(32'h1000_0000, 32'h0800_0000);
        send_trial(32'h1000_0000, 32'hF800_0000);
        drain();
        apb_write(REG_LOCATION, 32'h8000_0000);
        send_trial(32'h1000_0000, 32'hF800_0000);
        send_trial(32'h1000_0000, 32'h0800_0000);
        drain();

        // Random phases across several register settings, extremes included.
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    apb_write(REG_LOCATION, 32'h0);
                    apb_write(REG_CONCENTRATION, 32'h0);
                    apb_write(REG_SCALE, SCALE_RST);
                end
                1: begin
                    apb_write(REG_CONCENTRATION, 32'h000A_0000);  // k = 10
                    apb_write(REG_SCALE, 32'h143D_136A);          // 1/sqrt(10)
                end
                2: begin
                    apb_write(REG_CONCENTRATION, 32'hFFFF_FFFF);
                    apb_write(REG_SCALE, 32'h0000_0100);
                end
                3: begin
                    apb_write(REG_CONCENTRATION, 32'h0000_0001);
                    apb_write(REG_SCALE, 32'hFFFF_FFFF);
                end
                4: begin
                    apb_write(REG_LOCATION, 32'h7FFF_FFFF);
                    apb_write(REG_CONCENTRATION, CONCENTRATION_RST);
                    apb_write(REG_SCALE, 32'h0);
                end
                5: begin
                    apb_write(REG_LOCATION, 32'h8000_0000);
                    apb_write(REG_SCALE, SCALE_RST);
                end
                6: begin
                    apb_write(REG_LOCATION, $urandom());
                    apb_write(REG_CONCENTRATION, $urandom_range(32'h0010_0000));
                    apb_write(REG_SCALE, $urandom());
                end
                default: begin
                    apb_write(REG_LOCATION, 32'h1921_FB54);
                    apb_write(REG_CONCENTRATION, 32'h0002_0000);
                    apb_write(REG_SCALE, 32'h2D41_3CCD);
                end
            endcase
            // Phase 0 runs without idling; the rest idle at random.
            idle_enable = (phase != 0);
            // Stall the receiver long enough to fill the pipe and stall the input.
            if (phase == 2) hold_off = 150;
            repeat (110) random_trial();
            // Pause the sender until every expected word has come back.
            if (phase == 4) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
                while (pending_results.size() != 0) @(negedge aclk);
            end
            repeat (5) random_trial();
            drain();
        end

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Timeout watchdog.
    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire
